[rtl/core/mloc_pkg.sv]
// Package for the mesh/light overlap cull core.
// Shared item types, input mode codes and configuration register indexes.
// No dependencies.
package mloc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Input item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_MESH  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused, dropped on entry

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_CNT  = 3'd4;

  // Incoming transaction payload
  typedef struct packed {
    logic [1:0]               mode;
    logic [4:0]               light_index;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic                     mesh_hidden;
    logic                     casts_no_shadow;
  } req_t;

  // Item travelling down the light cell chain: a light load or a mesh test
  typedef struct packed {
    logic                     is_load;
    logic [4:0]               idx;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] lo_z;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [COORD_W-1:0] hi_z;
    logic                     keep;
    logic [7:0]               slot;
    logic                     full;
    logic                     no_shadow;
    logic [MASK_W-1:0]        mask;
  } item_t;

  // Result transaction payload
  typedef struct packed {
    logic              in_range;
    logic [7:0]        draw_slot;
    logic              list_full;
    logic [MASK_W-1:0] light_mask;
    logic [MASK_W-1:0] shadow_mask;
  } rsp_t;

endpackage

[rtl/core/mloc_ifs.sv]
// Valid/ready channel interfaces for the mesh/light overlap cull core.
// Depends on mloc_pkg for widths.
interface mloc_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic [4:0]                          light_index;
  logic signed [mloc_pkg::COORD_W-1:0] box_min_x;
  logic signed [mloc_pkg::COORD_W-1:0] box_min_y;
  logic signed [mloc_pkg::COORD_W-1:0] box_min_z;
  logic signed [mloc_pkg::COORD_W-1:0] box_max_x;
  logic signed [mloc_pkg::COORD_W-1:0] box_max_y;
  logic signed [mloc_pkg::COORD_W-1:0] box_max_z;
  logic                                mesh_hidden;
  logic                                casts_no_shadow;

  modport source (
    output valid, mode, light_index, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, mesh_hidden, casts_no_shadow,
    input  ready
  );
  modport sink (
    input  valid, mode, light_index, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, mesh_hidden, casts_no_shadow,
    output ready
  );
endinterface

interface mloc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        in_range;
  logic [7:0]                  draw_slot;
  logic                        list_full;
  logic [mloc_pkg::MASK_W-1:0] light_mask;
  logic [mloc_pkg::MASK_W-1:0] shadow_mask;

  modport source (
    output valid, in_range, draw_slot, list_full, light_mask, shadow_mask,
    input  ready
  );
  modport sink (
    input  valid, in_range, draw_slot, list_full, light_mask, shadow_mask,
    output ready
  );
endinterface

[rtl/core/mloc_range.sv]
// Front end: four-stage squared-distance range test and draw slot counter.
// Feeds the light cell chain with loads and mesh tests. Depends on mloc_pkg.
module mloc_range #(
  parameter int unsigned MAX_DRAWN = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                vld_i,
  input  mloc_pkg::req_t                      req_i,
  input  logic signed [mloc_pkg::COORD_W-1:0] eye_x_i,
  input  logic signed [mloc_pkg::COORD_W-1:0] eye_y_i,
  input  logic signed [mloc_pkg::COORD_W-1:0] eye_z_i,
  input  logic [30:0]                         view_distance_i,
  output logic                                vld_o,
  output mloc_pkg::item_t                     item_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_DRAWN + 1);
  localparam int unsigned SLOT_W = (CNT_W > 8) ? CNT_W : 8;

  // stage A: raw transaction
  logic           a_vld_q;
  mloc_pkg::req_t a_q;

  // stage B: per-axis gap |min + max - 2*eye|
  logic           b_vld_q;
  mloc_pkg::req_t b_q;
  logic [32:0]    gx_q, gy_q, gz_q;
  logic signed [33:0] dx, dy, dz;
  logic [32:0]    gx_d, gy_d, gz_d;

  // stage C: squares and bound
  logic           c_vld_q;
  mloc_pkg::req_t c_q;
  logic           far_q;
  logic [63:0]    sqx_q, sqy_q, sqz_q, bound_q;
  logic [31:0]    lim;
  logic           far_d;

  // stage D: chain entry
  logic            d_vld_q;
  mloc_pkg::item_t d_q;
  logic            d_vld_d;
  mloc_pkg::item_t d_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [65:0]       sum;
  logic              near, keep, full;
  logic [SLOT_W-1:0] slot_wide;

  function automatic logic [32:0] abs34(logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    return m[32:0];
  endfunction

  always_comb begin
    dx = 34'(a_q.box_min_x) + 34'(a_q.box_max_x) - (34'(eye_x_i) <<< 1);
    dy = 34'(a_q.box_min_y) + 34'(a_q.box_max_y) - (34'(eye_y_i) <<< 1);
    dz = 34'(a_q.box_min_z) + 34'(a_q.box_max_z) - (34'(eye_z_i) <<< 1);
    gx_d = abs34(dx);
    gy_d = abs34(dy);
    gz_d = abs34(dz);
  end

  assign lim   = {view_distance_i, 1'b0};
  assign far_d = (gx_q > {1'b0, lim}) || (gy_q > {1'b0, lim}) || (gz_q > {1'b0, lim});

  always_comb begin
    sum  = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
    near = !far_q && (sum <= {2'b00, bound_q});
    keep = (c_q.mode == mloc_pkg::MODE_MESH) && !c_q.mesh_hidden && near;
    full = (cnt_q == CNT_W'(MAX_DRAWN));
    slot_wide = full ? SLOT_W'(MAX_DRAWN - 1) : SLOT_W'(cnt_q);

    cnt_d = cnt_q;
    if (c_vld_q) begin
      if (c_q.mode == mloc_pkg::MODE_FRAME) begin
        cnt_d = '0;
      end else if (keep && !full) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end

    d_vld_d        = c_vld_q && (c_q.mode != mloc_pkg::MODE_FRAME);
    d_d.is_load    = (c_q.mode == mloc_pkg::MODE_LOAD);
    d_d.idx        = c_q.light_index;
    d_d.lo_x       = c_q.box_min_x;
    d_d.lo_y       = c_q.box_min_y;
    d_d.lo_z       = c_q.box_min_z;
    d_d.hi_x       = c_q.box_max_x;
    d_d.hi_y       = c_q.box_max_y;
    d_d.hi_z       = c_q.box_max_z;
    d_d.keep       = keep;
    d_d.slot       = keep ? slot_wide[7:0] : 8'd0;
    d_d.full       = keep && full;
    d_d.no_shadow  = c_q.casts_no_shadow;
    d_d.mask       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      cnt_q   <= '0;
    end else if (adv_i) begin
      // mode 3 is swallowed here
      a_vld_q <= vld_i && (req_i.mode != mloc_pkg::MODE_SPARE);
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= d_vld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q     <= req_i;
      b_q     <= a_q;
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      gz_q    <= gz_d;
      c_q     <= b_q;
      far_q   <= far_d;
      // gaps beyond lim are caught by far_q, so 32 bits suffice here
      sqx_q   <= 64'(gx_q[31:0]) * 64'(gx_q[31:0]);
      sqy_q   <= 64'(gy_q[31:0]) * 64'(gy_q[31:0]);
      sqz_q   <= 64'(gz_q[31:0]) * 64'(gz_q[31:0]);
      bound_q <= 64'(lim) * 64'(lim);
      d_q     <= d_d;
    end
  end

  assign vld_o  = d_vld_q;
  assign item_o = d_q;

endmodule

[rtl/core/mloc_cell.sv]
// One light cell of the chain: holds a light box, captures loads addressed
// to it and sets its mask bit on passing meshes. Depends on mloc_pkg.
module mloc_cell #(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  mloc_pkg::item_t item_i,
  input  logic [5:0]      light_count_i,
  output logic            vld_o,
  output mloc_pkg::item_t item_o
);

  localparam logic [5:0] K_ID = 6'(K);

  logic signed [mloc_pkg::COORD_W-1:0] lo_x_q, lo_y_q, lo_z_q;
  logic signed [mloc_pkg::COORD_W-1:0] hi_x_q, hi_y_q, hi_z_q;

  logic            vld_q;
  mloc_pkg::item_t item_q, item_d;
  logic            hit, in_use, overlap;

  assign hit    = vld_i && item_i.is_load && ({1'b0, item_i.idx} == K_ID);
  assign in_use = K_ID < light_count_i;

  // inclusive box overlap on all three axes
  assign overlap = ($signed(item_i.lo_x) <= hi_x_q) && ($signed(item_i.hi_x) >= lo_x_q) &&
                   ($signed(item_i.lo_y) <= hi_y_q) && ($signed(item_i.hi_y) >= lo_y_q) &&
                   ($signed(item_i.lo_z) <= hi_z_q) && ($signed(item_i.hi_z) >= lo_z_q);

  always_comb begin
    item_d = item_i;
    // cells past the mask width shift the bit out
    if (vld_i && !item_i.is_load && item_i.keep && in_use && overlap) begin
      item_d.mask = item_i.mask | (mloc_pkg::MASK_W'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && hit) begin
      lo_x_q <= item_i.lo_x;
      lo_y_q <= item_i.lo_y;
      lo_z_q <= item_i.lo_z;
      hi_x_q <= item_i.hi_x;
      hi_y_q <= item_i.hi_y;
      hi_z_q <= item_i.hi_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/core/mesh_light_overlap_cull_core.sv]
// Mesh/light overlap cull core: top level with config registers, the cell
// chain and the result register. Depends on mloc_pkg, mloc_ifs, mloc_range, mloc_cell.
//
// Every transaction (light load, mesh test, frame start) enters a pipeline that
// takes one transaction per cycle while the result register is free or being
// taken; a stalled result holds the whole pipeline. Four front stages do the
// squared-distance test (gaps, 32x32 squares, sum and compare) and assign the
// draw slot, then the mesh walks a chain of MAX_LIGHTS light cells, one cell
// after another, each holding one light box and setting its own mask bit, and
// finally lands in the result register. Light loads travel the same chain and
// are written into their cell as they pass, so order between loads and meshes
// is kept exactly. Loads and frame starts give no result. The user must write
// configuration only while no transaction is in flight; the core itself does
// not enforce this.
module mesh_light_overlap_cull_core #(
  parameter int unsigned MAX_LIGHTS = 32,
  parameter int unsigned MAX_DRAWN  = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mloc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mloc_pkg::CFG_W-1:0]       cfg_wdata_i,
  mloc_req_if.sink                         req_i,
  mloc_rsp_if.source                       rsp_o
);

  logic signed [mloc_pkg::COORD_W-1:0] eye_x_q, eye_y_q, eye_z_q;
  logic [30:0] view_distance_q;
  logic [5:0]  light_count_q;

  logic           adv;
  mloc_pkg::req_t req;

  logic            chain_vld  [MAX_LIGHTS+1];
  mloc_pkg::item_t chain_item [MAX_LIGHTS+1];

  logic           out_vld_q, out_vld_d;
  mloc_pkg::rsp_t out_q, out_d;
  mloc_pkg::item_t last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_x_q         <= '0;
      eye_y_q         <= '0;
      eye_z_q         <= '0;
      view_distance_q <= '0;
      light_count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mloc_pkg::CFG_EYE_X:     eye_x_q         <= cfg_wdata_i;
        mloc_pkg::CFG_EYE_Y:     eye_y_q         <= cfg_wdata_i;
        mloc_pkg::CFG_EYE_Z:     eye_z_q         <= cfg_wdata_i;
        mloc_pkg::CFG_VIEW_DIST: view_distance_q <= cfg_wdata_i[30:0];
        mloc_pkg::CFG_LIGHT_CNT: light_count_q   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_comb begin
    req.mode            = req_i.mode;
    req.light_index     = req_i.light_index;
    req.box_min_x       = req_i.box_min_x;
    req.box_min_y       = req_i.box_min_y;
    req.box_min_z       = req_i.box_min_z;
    req.box_max_x       = req_i.box_max_x;
    req.box_max_y       = req_i.box_max_y;
    req.box_max_z       = req_i.box_max_z;
    req.mesh_hidden     = req_i.mesh_hidden;
    req.casts_no_shadow = req_i.casts_no_shadow;
  end

  mloc_range #(
    .MAX_DRAWN (MAX_DRAWN)
  ) u_range (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .vld_i           (req_i.valid),
    .req_i           (req),
    .eye_x_i         (eye_x_q),
    .eye_y_i         (eye_y_q),
    .eye_z_i         (eye_z_q),
    .view_distance_i (view_distance_q),
    .vld_o           (chain_vld[0]),
    .item_o          (chain_item[0])
  );

  for (genvar k = 0; k < MAX_LIGHTS; k++) begin : g_cell
    mloc_cell #(
      .K (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .vld_i         (chain_vld[k]),
      .item_i        (chain_item[k]),
      .light_count_i (light_count_q),
      .vld_o         (chain_vld[k+1]),
      .item_o        (chain_item[k+1])
    );
  end

  assign last = chain_item[MAX_LIGHTS];

  always_comb begin
    out_vld_d         = chain_vld[MAX_LIGHTS] && !last.is_load;
    out_d.in_range    = last.keep;
    out_d.draw_slot   = last.slot;
    out_d.list_full   = last.full;
    out_d.light_mask  = last.mask;
    out_d.shadow_mask = last.no_shadow ? '0 : last.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.in_range    = out_q.in_range;
  assign rsp_o.draw_slot   = out_q.draw_slot;
  assign rsp_o.list_full   = out_q.list_full;
  assign rsp_o.light_mask  = out_q.light_mask;
  assign rsp_o.shadow_mask = out_q.shadow_mask;

`ifndef SYNTHESIS
  a_culled_is_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.in_range |->
      out_q.light_mask == '0 && out_q.draw_slot == 8'd0 && !out_q.list_full)
    else $error("culled mesh carries a slot or mask");

  a_shadow_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.shadow_mask & ~out_q.light_mask) == '0)
    else $error("shadow mask has bits outside light mask");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.list_full |-> out_q.draw_slot == 8'(MAX_DRAWN - 1))
    else $error("full list without saturated slot");

  a_mask_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.light_mask >> light_count_q) == '0)
    else $error("mask bit set for a light not in use");
`endif

endmodule

[dv/tb_mesh_light_overlap_cull_core.sv]
// Testbench for mesh_light_overlap_cull_core: directed corner cases, then random
// light loads, frame starts and mesh tests, checked against an in-bench predictor.
// Depends on mloc_pkg, mloc_ifs and the core RTL.
`timescale 1ns / 1ps

module tb_mesh_light_overlap_cull_core;

  localparam int unsigned N_LIGHTS   = 32;
  localparam int unsigned N_DRAWN    = 256;
  localparam int unsigned LATENCY    = N_LIGHTS + 4;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int          ONE        = 65536;    // 1.0 in Q16.16
  localparam int          SCENE      = 1 << 24;  // random scene spans +/-256.0
  localparam logic [1:0]  M_LOAD     = mloc_pkg::MODE_LOAD;
  localparam logic [1:0]  M_MESH     = mloc_pkg::MODE_MESH;
  localparam logic [1:0]  M_FRAME    = mloc_pkg::MODE_FRAME;
  localparam logic [1:0]  M_SPARE    = mloc_pkg::MODE_SPARE;  // ignored by the core
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mloc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mloc_pkg::CFG_W-1:0]     cfg_wdata_i;

  mloc_req_if req_if ();
  mloc_rsp_if rsp_if ();

  mesh_light_overlap_cull_core #(
    .MAX_LIGHTS(N_LIGHTS),
    .MAX_DRAWN (N_DRAWN)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .req_i(req_if),
    .rsp_o(rsp_if)
  );

  // Predictor state: view registers, light table and the draw-slot counter
  logic signed [31:0] eye [3];
  logic [30:0]        view_dist;
  logic [5:0]         light_cnt;
  logic signed [31:0] lamp_lo [N_LIGHTS][3];
  logic signed [31:0] lamp_hi [N_LIGHTS][3];
  logic [8:0]         slot_cnt;
  mloc_pkg::rsp_t     verdicts_q [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatches     = 0;
  int n_items        = 0;
  int n_meshes       = 0;
  int n_kept         = 0;
  int n_full         = 0;
  int cycles         = 0;
  mloc_pkg::rsp_t seen, wanted;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, verdicts_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);

  // Works out the result of one accepted transaction and queues it for mesh tests
  function automatic void predict_cull(input mloc_pkg::req_t r);
    logic signed [31:0] mn [3], mx [3];
    longint             gap;
    logic [69:0]        g, sum, bound;
    mloc_pkg::rsp_t     v;
    int                 used;
    mn = '{r.box_min_x, r.box_min_y, r.box_min_z};
    mx = '{r.box_max_x, r.box_max_y, r.box_max_z};
    v  = '0;
    case (r.mode)
      M_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          lamp_lo[r.light_index][a] = mn[a];
          lamp_hi[r.light_index][a] = mx[a];
        end
      end
      M_FRAME: slot_cnt = '0;
      M_MESH: begin
        // doubled midpoint against doubled distance, so no rounding anywhere
        bound = 70'(view_dist) << 1;
        bound = bound * bound;
        sum   = '0;
        for (int a = 0; a < 3; a++) begin
          gap = longint'(mn[a]) + longint'(mx[a]) - 2 * longint'(eye[a]);
          if (gap < 0) gap = -gap;
          g   = 70'(gap);
          sum += g * g;
        end
        if (!r.mesh_hidden && sum <= bound) begin
          v.in_range = 1'b1;
          if (slot_cnt < N_DRAWN) begin
            v.draw_slot = slot_cnt[7:0];
            slot_cnt++;
          end else begin
            v.draw_slot = 8'(N_DRAWN - 1);
            v.list_full = 1'b1;
          end
          used = (light_cnt < N_LIGHTS) ? int'(light_cnt) : N_LIGHTS;
          for (int k = 0; k < used; k++) begin
            if (mn[0] <= lamp_hi[k][0] && mx[0] >= lamp_lo[k][0] &&
                mn[1] <= lamp_hi[k][1] && mx[1] >= lamp_lo[k][1] &&
                mn[2] <= lamp_hi[k][2] && mx[2] >= lamp_lo[k][2])
              v.light_mask[k] = 1'b1;
          end
          v.shadow_mask = r.casts_no_shadow ? '0 : v.light_mask;
        end
        verdicts_q.push_back(v);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen = {rsp_if.in_range, rsp_if.draw_slot, rsp_if.list_full,
              rsp_if.light_mask, rsp_if.shadow_mask};
      if (verdicts_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result transaction with nothing expected: range=%b slot=%0d",
                   $time, seen.in_range, seen.draw_slot);
      end else begin
        wanted = verdicts_q.pop_front();
        n_meshes++;
        if (wanted.in_range) n_kept++;
        if (wanted.list_full) n_full++;
        if (seen.in_range !== wanted.in_range || seen.draw_slot !== wanted.draw_slot ||
            seen.list_full !== wanted.list_full || seen.light_mask !== wanted.light_mask ||
            seen.shadow_mask !== wanted.shadow_mask) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] mismatch: got range=%b slot=%0d full=%b mask=%h shadow=%h",
                     $time, seen.in_range, seen.draw_slot, seen.list_full,
                     seen.light_mask, seen.shadow_mask);
            $display("              want range=%b slot=%0d full=%b mask=%h shadow=%h",
                     wanted.in_range, wanted.draw_slot, wanted.list_full,
                     wanted.light_mask, wanted.shadow_mask);
          end
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input mloc_pkg::req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.mode            <= r.mode;
    req_if.light_index     <= r.light_index;
    req_if.box_min_x       <= r.box_min_x;
    req_if.box_min_y       <= r.box_min_y;
    req_if.box_min_z       <= r.box_min_z;
    req_if.box_max_x       <= r.box_max_x;
    req_if.box_max_y       <= r.box_max_y;
    req_if.box_max_z       <= r.box_max_z;
    req_if.mesh_hidden     <= r.mesh_hidden;
    req_if.casts_no_shadow <= r.casts_no_shadow;
    do @(posedge clk_i); while (!req_if.ready);
    predict_cull(r);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (verdicts_q.size() != 0) @(negedge clk_i);
  endtask

  // Loads and frame starts leave no result, so give the chain time to empty
  task automatic drain_pipeline();
    hold_until_drained();
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_view(input logic [31:0] ex, ey, ez, vd, lc);
    logic [mloc_pkg::CFG_W-1:0]     vals [5];
    logic [mloc_pkg::CFG_IDX_W-1:0] idxs [5];
    vals = '{ex, ey, ez, vd, lc};
    idxs = '{mloc_pkg::CFG_EYE_X, mloc_pkg::CFG_EYE_Y, mloc_pkg::CFG_EYE_Z,
             mloc_pkg::CFG_VIEW_DIST, mloc_pkg::CFG_LIGHT_CNT};
    drain_pipeline();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idxs[i];
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    eye[0]    = ex;
    eye[1]    = ey;
    eye[2]    = ez;
    view_dist = vd[30:0];
    light_cnt = lc[5:0];
  endtask

  function automatic mloc_pkg::req_t mk_item(input logic [1:0] mode, input logic [4:0] idx,
                                   input logic signed [31:0] x0, y0, z0, x1, y1, z1,
                                   input logic hidden = 1'b0, input logic no_shadow = 1'b0);
    mloc_pkg::req_t r;
    r = '{mode, idx, x0, y0, z0, x1, y1, z1, hidden, no_shadow};
    return r;
  endfunction

  // Random box in the scene; an axis is now and then full-range noise or inverted
  function automatic mloc_pkg::req_t rand_box(input int half_max);
    mloc_pkg::req_t     r;
    logic signed [31:0] lo [3], hi [3], t;
    int                 c, h;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(99) < 5) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else begin
        c     = int'($urandom_range(2 * SCENE)) - SCENE;
        h     = int'($urandom_range(half_max));
        lo[a] = c - h;
        hi[a] = c + h;
        if ($urandom_range(99) < 4) begin
          t     = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    r = mk_item(M_MESH, 5'($urandom_range(31)), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                1'($urandom), 1'($urandom));
    return r;
  endfunction

  task automatic test_directed_corners();
    // reset view: distance 0, no lights, so only the eye point itself is kept
    send_item(mk_item(M_MESH, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(M_SPARE, 0, 0, 0, 0, 0, 0, 0));
    write_view(0, 0, 0, 5 * ONE, 0);
    send_item(mk_item(M_LOAD, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_item(mk_item(M_LOAD, 31, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    send_item(mk_item(M_LOAD, 1, 2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));
    write_view(0, 0, 0, 5 * ONE, 2);
    send_item(mk_item(M_FRAME, 0, 0, 0, 0, 0, 0, 0));
    // touches both lights exactly on their faces
    send_item(mk_item(M_MESH, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
    send_item(mk_item(M_MESH, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b0, 1'b1));
    send_item(mk_item(M_MESH, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b1, 1'b0));
    // 3-4-5 triangle: on the sphere, then one ulp past it
    send_item(mk_item(M_MESH, 0, 3 * ONE, 4 * ONE, 0, 3 * ONE, 4 * ONE, 0));
    send_item(mk_item(M_MESH, 0, 3 * ONE, 4 * ONE, 1, 3 * ONE, 4 * ONE, 1));
    // midpoint half an ulp beyond the limit must be dropped
    send_item(mk_item(M_MESH, 0, 0, 0, 0, 10 * ONE + 1, 0, 0));
    send_item(mk_item(M_MESH, 0, 0, 0, 0, 10 * ONE, 0, 0));
    send_item(mk_item(M_MESH, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, 1'b0, 1'b1));
    send_item(mk_item(M_FRAME, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(M_MESH, 0, -ONE, 0, 0, 0, ONE, ONE));
    write_view(C_MIN, C_MAX, C_MIN, C_MAX, 2);
    send_item(mk_item(M_MESH, 0, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN));
    send_item(mk_item(M_MESH, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    write_view(C_MAX, C_MIN, C_MAX, C_MAX, 0);
    send_item(mk_item(M_MESH, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    write_view(0, 0, 0, 0, 0);
    send_item(mk_item(M_MESH, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_item(mk_item(M_MESH, 0, 1, 0, 0, 1, 0, 0));
  endtask

  // Every entry gets a box before any light count can reach it
  task automatic fill_light_table();
    mloc_pkg::req_t r;
    for (int i = 0; i < N_LIGHTS; i++) begin
      r             = rand_box(1 << 23);
      r.mode        = M_LOAD;
      r.light_index = 5'(i);
      send_item(r);
    end
  endtask

  task automatic test_light_count_extremes();
    logic [31:0] counts [2];
    counts = '{32, 63};
    foreach (counts[j]) begin
      write_view(0, 0, 0, C_MAX, counts[j]);
      send_item(mk_item(M_FRAME, 0, 0, 0, 0, 0, 0, 0));
      repeat (6) send_item(rand_box(1 << 23));
    end
  endtask

  task automatic run_random(input int n, idle, stall, frame_pct, hidden_pct);
    mloc_pkg::req_t r;
    int   sent, pick;
    bit   paused;
    src_idle_pct   = idle;
    sink_stall_pct = stall;
    sent           = 0;
    paused         = 1'b0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < frame_pct) begin
        r      = rand_box(1 << 22);
        r.mode = M_FRAME;
      end else if (pick < frame_pct + 8) begin
        r      = rand_box(1 << 23);
        r.mode = M_LOAD;
      end else if (pick < frame_pct + 10) begin
        r      = rand_box(1 << 22);
        r.mode = M_SPARE;
      end else begin
        r             = rand_box(1 << 22);
        r.mesh_hidden = ($urandom_range(99) < hidden_pct);
      end
      send_item(r);
      if (r.mode != M_SPARE) sent++;
      if (!paused && sent >= n / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end
  endtask

  function automatic logic [31:0] rand_eye();
    return 32'(int'($urandom_range(1 << 23)) - (1 << 22));
  endfunction

  task automatic test_random_phases();
    int idle [3], stall [3];
    idle  = '{0, 76, 0};
    stall = '{0, 0, 76};
    for (int p = 0; p < 3; p++) begin
      write_view(rand_eye(), rand_eye(), rand_eye(),
                 $urandom_range(1 << 22, 1 << 25), $urandom_range(1, 32));
      run_random(50, idle[p], stall[p], 3, 10);
    end
  endtask

  // One opening frame start, then none, and an unlimited view, so the draw list saturates
  task automatic test_slot_saturation();
    write_view(rand_eye(), rand_eye(), rand_eye(), C_MAX, $urandom_range(0, 32));
    send_item(mk_item(M_FRAME, 0, 0, 0, 0, 0, 0, 0));
    run_random(400, 32, 32, 0, 3);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.mode            = M_LOAD;
    req_if.light_index     = '0;
    req_if.box_min_x       = '0;
    req_if.box_min_y       = '0;
    req_if.box_min_z       = '0;
    req_if.box_max_x       = '0;
    req_if.box_max_y       = '0;
    req_if.box_max_z       = '0;
    req_if.mesh_hidden     = 1'b0;
    req_if.casts_no_shadow = 1'b0;
    rsp_if.ready           = 1'b0;
    eye                    = '{0, 0, 0};
    view_dist              = '0;
    light_cnt              = '0;
    slot_cnt               = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    fill_light_table();
    test_light_count_extremes();
    test_random_phases();
    test_slot_saturation();

    drain_pipeline();
    mismatches += verdicts_q.size();
    $display("Sent %0d transactions; checked %0d mesh results, %0d kept, %0d on a full list",
             n_items, n_meshes, n_kept, n_full);
    $display("Covered view/eye extremes, light counts 0 to 63, idle and stall mixes; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mloc_pkg.sv
rtl/core/mloc_ifs.sv
rtl/core/mloc_range.sv
rtl/core/mloc_cell.sv
rtl/core/mesh_light_overlap_cull_core.sv
dv/tb_mesh_light_overlap_cull_core.sv
